[design/bac_pkg.sv]
// Shared types, codes and sizes for the breakpoint address comparator.
package bac_pkg;

	// Table size and derived widths
	localparam int ENTRIES = 8;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SLOT_W  = 3;
	localparam int CNT_W   = 4;
	localparam logic [31:0] TRAP_WORD = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		ACT_SET   = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_CHECK = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_NOTFOUND = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		KIND_EQ   = 3'd0,
		KIND_GT   = 3'd1,
		KIND_GE   = 3'd2,
		KIND_LT   = 3'd3,
		KIND_LE   = 3'd4,
		KIND_IN   = 3'd5,
		KIND_OUT  = 3'd6,
		KIND_MASK = 3'd7
	} kind_t;

	// Request beat
	typedef struct packed {
		logic [1:0]        action;
		logic [31:0]       address;
		logic [2:0]        kind;
		logic [15:0]       bound;
		logic [SLOT_W-1:0] slot_in;
		logic [31:0]       event_type;
		logic [31:0]       instruction;
	} req_t;

	// Response beat
	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot_out;
		logic              hit;
		logic [CNT_W-1:0]  match_count;
	} rsp_t;

	// One breakpoint table entry
	typedef struct packed {
		logic [31:0] address;
		logic [2:0]  kind;
		logic [15:0] bound;
	} entry_t;

	// Table write and clear controls
	typedef struct packed {
		logic             set_en;
		logic [IDX_W-1:0] set_idx;
		entry_t           set_entry;
		logic             clr_en;
		logic [IDX_W-1:0] clr_idx;
	} tbl_ctl_t;

endpackage

[design/breakpoint_address_comparator.sv]
// Top level: request sequencer, breakpoint table and shared compare unit.
//
// Set, clear, unused action codes and checks that do not qualify (event type
// nonzero or instruction not all ones) need no table walk: the response beat
// is valid on the cycle after the request is accepted. A qualifying check walks
// the table one entry per cycle through a single compare unit; req_stall stays
// high during the walk. The response sits in an output register, so a new
// request is taken while the previous response waits, as long as that
// register will be free. Set takes the lowest free slot and returns its index;
// a full table returns status full. match_count saturates at 15.
module breakpoint_address_comparator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bac_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bac_pkg::rsp_t rsp
);
	import bac_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_DONE
	} state_t;

	state_t             state_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	logic [31:0]        trap_addr_q;
	logic [IDX_W-1:0]   idx_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               accept;
	logic               qualify;
	logic               slot_in_range;
	logic [IDX_W-1:0]   slot_idx;
	logic               out_free;
	logic               rsp_load;
	rsp_t               rsp_next;
	tbl_ctl_t           tbl_ctl;
	entry_t             rd_entry;
	logic [ENTRIES-1:0] valid;
	logic               free_found;
	logic [IDX_W-1:0]   free_idx;
	logic               match;

	// Request handshake
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE) || !out_free;
	assign accept    = req_valid && !req_stall;

	assign qualify       = (req.event_type == '0) && (req.instruction == TRAP_WORD);
	assign slot_in_range = (32'(req.slot_in) < 32'(ENTRIES));
	assign slot_idx      = IDX_W'(req.slot_in);

	// Table write controls
	always_comb begin
		tbl_ctl                   = '0;
		tbl_ctl.set_en            = accept && (req.action == ACT_SET) && free_found;
		tbl_ctl.set_idx           = free_idx;
		tbl_ctl.set_entry.address = req.address;
		tbl_ctl.set_entry.kind    = req.kind;
		tbl_ctl.set_entry.bound   = req.bound;
		tbl_ctl.clr_en            = accept && (req.action == ACT_CLEAR) && slot_in_range
		                            && valid[slot_idx];
		tbl_ctl.clr_idx           = slot_idx;
	end

	bac_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (tbl_ctl),
		.rd_idx     (idx_q),
		.rd_entry   (rd_entry),
		.valid      (valid),
		.free_found (free_found),
		.free_idx   (free_idx)
	);

	bac_cmp u_cmp (
		.ent       (rd_entry),
		.trap_addr (trap_addr_q),
		.match     (match)
	);

	// Build the next response beat and decide when to load it
	always_comb begin
		rsp_load = 1'b0;
		rsp_next = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.action)
						ACT_SET: begin
							rsp_load = 1'b1;
							if (free_found) begin
								rsp_next.status   = STAT_OK;
								rsp_next.slot_out = SLOT_W'(free_idx);
							end else begin
								rsp_next.status = STAT_FULL;
							end
						end
						ACT_CLEAR: begin
							rsp_load = 1'b1;
							if (slot_in_range && valid[slot_idx]) begin
								rsp_next.status = STAT_OK;
							end else begin
								rsp_next.status = STAT_NOTFOUND;
							end
						end
						ACT_CHECK: begin
							rsp_load = !qualify;
						end
						default: begin
							rsp_load = 1'b1;
						end
					endcase
				end
			end
			S_DONE: begin
				// Hold until the output register frees up
				rsp_load             = out_free;
				rsp_next.status      = STAT_OK;
				rsp_next.hit         = (cnt_q != '0);
				rsp_next.match_count = cnt_q;
			end
			default: ;
		endcase
	end

	// Sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			trap_addr_q <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
		end else begin
			// Load a new response, or drop the current one once taken
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= rsp_next;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (req.action == ACT_CHECK) && qualify) begin
						trap_addr_q <= req.address;
						idx_q       <= '0;
						cnt_q       <= '0;
						state_q     <= S_WALK;
					end
				end
				S_WALK: begin
					// Count hits, saturating
					if (valid[idx_q] && match && (cnt_q != '1)) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (idx_q == IDX_W'(ENTRIES - 1)) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[design/bac_cmp.sv]
// Shared compare unit: tests one table entry against the trap address.
module bac_cmp (
	input  bac_pkg::entry_t ent,
	input  logic [31:0]     trap_addr,
	output logic            match
);
	import bac_pkg::*;

	logic [31:0] range_end;
	logic [31:0] bound_ext;

	// Range end wraps at 32 bits
	assign bound_ext = 32'(ent.bound);
	assign range_end = ent.address + bound_ext;

	// Select the comparison by the entry's kind
	always_comb begin
		case (kind_t'(ent.kind))
			KIND_EQ:   match = (trap_addr == ent.address);
			KIND_GT:   match = (trap_addr > ent.address);
			KIND_GE:   match = (trap_addr >= ent.address);
			KIND_LT:   match = (trap_addr < ent.address);
			KIND_LE:   match = (trap_addr <= ent.address);
			KIND_IN:   match = (ent.address <= trap_addr) && (trap_addr < range_end);
			KIND_OUT:  match = (ent.address > trap_addr) || (trap_addr >= range_end);
			KIND_MASK: match = ((trap_addr & bound_ext) == ent.address);
			default:   match = 1'b0;
		endcase
	end

endmodule

[design/bac_table.sv]
// Breakpoint table: valid bits, entry storage and lowest-free-slot search.
module bac_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bac_pkg::tbl_ctl_t           ctl,
	input  logic [bac_pkg::IDX_W-1:0]   rd_idx,
	output bac_pkg::entry_t             rd_entry,
	output logic [bac_pkg::ENTRIES-1:0] valid,
	output logic                        free_found,
	output logic [bac_pkg::IDX_W-1:0]   free_idx
);
	import bac_pkg::*;

	logic [ENTRIES-1:0] valid_q;
	entry_t             entry_q [ENTRIES];

	// Track which slots are in use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ctl.set_en) begin
				valid_q[ctl.set_idx] <= 1'b1;
			end
			if (ctl.clr_en) begin
				valid_q[ctl.clr_idx] <= 1'b0;
			end
		end
	end

	// Store entry payload on set
	always_ff @(posedge clk) begin
		if (ctl.set_en) begin
			entry_q[ctl.set_idx] <= ctl.set_entry;
		end
	end

	// Find the lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	assign rd_entry = entry_q[rd_idx];
	assign valid    = valid_q;

endmodule
